// File: hw/rtl/chxor_pkg.sv
// Shared types and codes for the chained XOR packet cipher.
package chxor_pkg;

   localparam int unsigned ByteWidth = 8;

   typedef logic [ByteWidth-1:0] byte_type;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } opcode_type;

   // One accepted item as held in the input register.
   typedef struct packed {
      opcode_type opcode;
      byte_type   data_byte;
      byte_type   rand_key;
      logic       first_byte;
      logic       last_byte;
   } req_item_type;

   // One result item as held in the result register.
   typedef struct packed {
      byte_type out_byte;
      byte_type plain_sum;
      logic     last_out;
   } rsp_item_type;

endpackage

// File: hw/rtl/chained_xor_packet_cipher.sv
// Top level of the chained XOR packet cipher: input register, coding logic, result register.
// An accepted byte is held in the input register; when it moves on, its result is loaded into
// the result register with rsp_valid high, and from there it leaves on a result transfer.
// Throughput: one byte per cycle unless rsp_ready stalls; the chaining state is updated
// in the cycle a byte leaves the input register, so the next byte sees it without a bubble.
// Reset (synchronous, active high) clears both valid flags, the fixed key, the position,
// the chain values, the latched random key and the payload sum.
module chained_xor_packet_cipher (
   input  logic                clock,
   input  logic                reset,
   // Input channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  chxor_pkg::byte_type req_data_byte,
   input  chxor_pkg::byte_type req_rand_key,
   input  logic                req_first_byte,
   input  logic                req_last_byte,
   // Result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output chxor_pkg::byte_type rsp_out_byte,
   output chxor_pkg::byte_type rsp_plain_sum,
   output logic                rsp_last_out,
   // Configuration port for the fixed key
   input  logic                csr_wr_en,
   input  chxor_pkg::byte_type csr_wr_data
);

   import chxor_pkg::*;

   // ------------------------------------------------------------------
   // Pipeline registers. The input register holds one accepted byte; the
   // result register holds one finished result until its transfer.
   // ------------------------------------------------------------------
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff, s1_item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   // Cipher state, as carried from one byte to the next.
   byte_type fixed_key_ff, fixed_key_in;
   byte_type pos_ff, pos_in;
   byte_type prev_inner_ff, prev_inner_in;
   byte_type prev_outer_ff, prev_outer_in;
   byte_type rkey_ff, rkey_in;
   byte_type sum_ff, sum_in;

   // The byte in the input register moves on when the result register is
   // empty or is being emptied in this cycle.
   logic s1_advance;
   logic req_xfer;

   // Effective state for the byte being coded: a first byte starts from
   // zero chain values and its own random key.
   byte_type cur_pos, cur_inner, cur_outer, cur_rkey, cur_sum;
   byte_type i1;
   byte_type inner_mask, outer_mask;
   byte_type inner_val, outer_val, plain_val, result_val;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_xfer   = req_valid && req_ready;

   always_comb begin
      if (s1_item_ff.first_byte) begin
         cur_pos   = '0;
         cur_inner = '0;
         cur_outer = '0;
         cur_sum   = '0;
         cur_rkey  = s1_item_ff.rand_key;
      end else begin
         cur_pos   = pos_ff;
         cur_inner = prev_inner_ff;
         cur_outer = prev_outer_ff;
         cur_sum   = sum_ff;
         cur_rkey  = rkey_ff;
      end

      i1 = cur_pos + byte_type'(1);

      // Both keystream bytes are independent of the data, so either
      // direction is just two XORs once they are formed.
      inner_mask = cur_rkey + i1 + cur_inner;
      outer_mask = fixed_key_ff + i1 + cur_outer;

      unique case (s1_item_ff.opcode)
         OP_ENCODE: begin
            plain_val  = s1_item_ff.data_byte;
            inner_val  = plain_val ^ inner_mask;
            outer_val  = inner_val ^ outer_mask;
            result_val = outer_val;
         end
         OP_DECODE: begin
            outer_val  = s1_item_ff.data_byte;
            inner_val  = outer_val ^ outer_mask;
            plain_val  = inner_val ^ inner_mask;
            result_val = plain_val;
         end
         default: begin
            plain_val  = s1_item_ff.data_byte;
            inner_val  = plain_val;
            outer_val  = plain_val;
            result_val = plain_val;
         end
      endcase
   end

   // Next-state logic for all registers.
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_item_in    = s1_item_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_item_in   = rsp_item_ff;
      fixed_key_in  = fixed_key_ff;
      pos_in        = pos_ff;
      prev_inner_in = prev_inner_ff;
      prev_outer_in = prev_outer_ff;
      rkey_in       = rkey_ff;
      sum_in        = sum_ff;

      if (csr_wr_en) begin
         fixed_key_in = csr_wr_data;
      end

      // A transfer on the result side empties the result register unless
      // a new result replaces it below.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_advance) begin
         rsp_valid_in          = 1'b1;
         rsp_item_in.out_byte  = result_val;
         rsp_item_in.last_out  = s1_item_ff.last_byte;
         // The checksum byte, and any byte at a wrapped position zero, is
         // left out of the payload sum.
         if (cur_pos != '0) begin
            rsp_item_in.plain_sum = cur_sum + plain_val;
         end else begin
            rsp_item_in.plain_sum = cur_sum;
         end
         sum_in        = rsp_item_in.plain_sum;
         pos_in        = i1;
         prev_inner_in = inner_val;
         prev_outer_in = outer_val;
         rkey_in       = cur_rkey;
         s1_valid_in   = 1'b0;
      end

      if (req_xfer) begin
         s1_valid_in           = 1'b1;
         s1_item_in.opcode     = opcode_type'(req_opcode);
         s1_item_in.data_byte  = req_data_byte;
         s1_item_in.rand_key   = req_rand_key;
         s1_item_in.first_byte = req_first_byte;
         s1_item_in.last_byte  = req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fixed_key_ff  <= '0;
         pos_ff        <= '0;
         prev_inner_ff <= '0;
         prev_outer_ff <= '0;
         rkey_ff       <= '0;
         sum_ff        <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fixed_key_ff  <= fixed_key_in;
         pos_ff        <= pos_in;
         prev_inner_ff <= prev_inner_in;
         prev_outer_ff <= prev_outer_in;
         rkey_ff       <= rkey_in;
         sum_ff        <= sum_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_item_ff.out_byte;
   assign rsp_plain_sum = rsp_item_ff.plain_sum;
   assign rsp_last_out  = rsp_item_ff.last_out;

`ifndef SYNTHESIS
   // A byte that leaves the input register always lands in the result register.
   assert property (@(posedge clock) disable iff (reset) s1_advance |=> rsp_valid)
      else $error("result register not loaded after a byte left the input register");

   // After a first byte, the position has moved on to one.
   assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_item_ff.first_byte |=> pos_ff == byte_type'(1))
      else $error("position not restarted by a first byte");

   // The checksum byte of a new packet contributes nothing to the sum.
   assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_item_ff.first_byte |=> rsp_plain_sum == '0)
      else $error("payload sum not cleared on a first byte");

   // An empty input register never refuses a transfer.
   assert property (@(posedge clock) disable iff (reset) !s1_valid_ff |-> req_ready)
      else $error("input refused while the input register is empty");
`endif

endmodule
